// File: hdl/mrci_pkg.sv
// ----------------------------------------------------------------------------
// mrci_pkg
// Shared types and constants for the matrix row/column insert/remove engine:
// command and status codes, row cell operations and the cell control request.
// ----------------------------------------------------------------------------
package mrci_pkg;

  localparam int DATA_W = 32;
  // index and count widths cover the largest supported dimension of 16
  localparam int KW     = 4;
  localparam int NW     = 5;

  typedef enum logic [2:0] {
    CMD_SET_SIZE = 3'd0,
    CMD_WRITE    = 3'd1,
    CMD_STAGE    = 3'd2,
    CMD_INS_ROW  = 3'd3,
    CMD_REM_ROW  = 3'd4,
    CMD_INS_COL  = 3'd5,
    CMD_REM_COL  = 3'd6,
    CMD_READ     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_POS   = 2'd2,
    ST_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_ROW_LOAD,
    OP_COL_LOAD,
    OP_ROW_SWAP,
    OP_COL_SWAP
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    cell_op_t          op;
    logic [KW-1:0]     row_k;
    logic [KW-1:0]     col_k;
    logic [NW-1:0]     rc;
    logic [NW-1:0]     cc;
    logic [DATA_W-1:0] wdata;
  } cell_ctrl_t;

endpackage

// File: hdl/mrci_row.sv
// ----------------------------------------------------------------------------
// mrci_row
// One matrix row cell. Holds a row of words, swaps its words pairwise, swaps
// its row with a neighbor row cell, loads staged data and serves cell access.
// ----------------------------------------------------------------------------
module mrci_row
  import mrci_pkg::*;
#(
  parameter int MAX_DIM = 8,
  parameter int ROW     = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cell_ctrl_t                       ctrl,
  input  logic [MAX_DIM-1:0][DATA_W-1:0]   staged,
  input  logic [MAX_DIM-1:0][DATA_W-1:0]   below,
  input  logic [MAX_DIM-1:0][DATA_W-1:0]   above,
  output logic [MAX_DIM-1:0][DATA_W-1:0]   words,
  output logic [DATA_W-1:0]                rd_word
);

  localparam int            IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [KW-1:0] ROW_K = KW'(ROW);

  logic [MAX_DIM-1:0][DATA_W-1:0] words_next;
  logic [MAX_DIM-1:0][DATA_W-1:0] left_w;
  logic [MAX_DIM-1:0][DATA_W-1:0] right_w;
  logic                           row_on;
  logic                           row_is_k;
  logic                           row_is_k1;

  assign row_on    = NW'(ROW_K) < ctrl.rc;
  assign row_is_k  = ctrl.row_k == ROW_K;
  assign row_is_k1 = (ctrl.row_k + KW'(1)) == ROW_K;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_nb
    if (c == MAX_DIM - 1) begin : g_last
      assign right_w[c] = '0;
    end else begin : g_mid
      assign right_w[c] = words[c+1];
    end
    if (c == 0) begin : g_first
      assign left_w[c] = '0;
    end else begin : g_rest
      assign left_w[c] = words[c-1];
    end
  end

  always_comb begin
    words_next = words;
    for (int c = 0; c < MAX_DIM; c++) begin
      case (ctrl.op)
        OP_WRITE: begin
          if (row_is_k && ctrl.col_k == KW'(c)) words_next[c] = ctrl.wdata;
        end
        OP_ROW_LOAD: begin
          if (row_is_k && NW'(c) < ctrl.cc) words_next[c] = staged[c];
        end
        OP_COL_LOAD: begin
          if (row_on && ctrl.col_k == KW'(c)) words_next[c] = staged[ROW];
        end
        OP_ROW_SWAP: begin
          if (NW'(c) < ctrl.cc) begin
            if (row_is_k) words_next[c] = above[c];
            else if (row_is_k1) words_next[c] = below[c];
          end
        end
        OP_COL_SWAP: begin
          if (row_on) begin
            if (ctrl.col_k == KW'(c)) words_next[c] = right_w[c];
            else if ((ctrl.col_k + KW'(1)) == KW'(c)) words_next[c] = left_w[c];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words <= '0;
    end else begin
      words <= words_next;
    end
  end

  assign rd_word = words[ctrl.col_k[IW-1:0]];

endmodule

// File: hdl/matrix_row_column_insert_remove_top.sv
// ----------------------------------------------------------------------------
// matrix_row_column_insert_remove_top
// Matrix of up to MAX_DIM x MAX_DIM signed words with row/column insert and
// remove. A request is taken when start is high and busy is low; in the cycle
// after the accepting edge (S_EXEC) the block checks it and applies it, and
// the result is then shown for exactly one cycle with done high (status,
// data and the counts after the request). The receiver cannot stall the
// result, so it must take it in that cycle. Set size, write, stage and read
// go from S_EXEC straight to S_DONE. Insert and remove stay in S_SHIFT for
// every row or column that moves: the rows (or columns) are moved by a
// chain of row cells that swap neighbor pairs, one pair a cycle, so an
// insert at position p with n rows or columns in use makes n - p swaps and
// a remove n - p - 1. busy stays high through the done cycle, so the next
// request is taken in S_IDLE after it at the earliest: the block takes no
// new request before it is through with the last one.
// ----------------------------------------------------------------------------
module matrix_row_column_insert_remove_top
  import mrci_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [2:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic [3:0]         position,
  input  logic [3:0]         rows_in,
  input  logic [3:0]         cols_in,
  input  logic [2:0]         slot,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic [3:0]         rows_now,
  output logic [3:0]         cols_now
);

  localparam int            IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int            CW    = $clog2(MAX_DIM + 1);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_DIM);

  state_t                         state;
  state_t                         state_next;
  cmd_t                           req_cmd;
  logic [KW-1:0]                  req_row;
  logic [KW-1:0]                  req_col;
  logic [KW-1:0]                  req_slot;
  logic [NW-1:0]                  req_pos;
  logic [NW-1:0]                  req_rin;
  logic [NW-1:0]                  req_cin;
  logic [DATA_W-1:0]              req_value;
  logic [CW-1:0]                  rc;
  logic [CW-1:0]                  cc;
  logic [CW-1:0]                  rc_next;
  logic [CW-1:0]                  cc_next;
  logic [NW-1:0]                  rc_n;
  logic [NW-1:0]                  cc_n;
  logic [KW-1:0]                  k;
  logic [KW-1:0]                  k_next;
  logic [KW-1:0]                  k_end;
  logic [KW-1:0]                  k_end_next;
  logic                           k_up;
  logic                           k_up_next;
  logic                           k_col;
  logic                           k_col_next;
  logic [MAX_DIM-1:0][DATA_W-1:0] staged;
  status_t                        exec_status;
  status_t                        res_status;
  logic [DATA_W-1:0]              res_data;
  logic [DATA_W-1:0]              rd_sel;
  logic                           exec_shift;
  cell_ctrl_t                     ctrl;
  logic [MAX_DIM-1:0][DATA_W-1:0] row_words [MAX_DIM];
  logic [DATA_W-1:0]              row_rd [MAX_DIM];

  assign rc_n = NW'(rc);
  assign cc_n = NW'(cc);

  // row cell chain
  for (genvar r = 0; r < MAX_DIM; r++) begin : g_row
    logic [MAX_DIM-1:0][DATA_W-1:0] below_w;
    logic [MAX_DIM-1:0][DATA_W-1:0] above_w;
    if (r == 0) begin : g_first
      assign below_w = '0;
    end else begin : g_rest
      assign below_w = row_words[r-1];
    end
    if (r == MAX_DIM - 1) begin : g_last
      assign above_w = '0;
    end else begin : g_mid
      assign above_w = row_words[r+1];
    end
    mrci_row #(
      .MAX_DIM (MAX_DIM),
      .ROW     (r)
    ) u_row (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .staged  (staged),
      .below   (below_w),
      .above   (above_w),
      .words   (row_words[r]),
      .rd_word (row_rd[r])
    );
  end

  assign rd_sel = row_rd[req_row[IW-1:0]];

  // request check and bookkeeping
  always_comb begin
    exec_status = ST_OK;
    exec_shift  = 1'b0;
    rc_next     = rc;
    cc_next     = cc;
    k_next      = k;
    k_end_next  = k_end;
    k_up_next   = k_up;
    k_col_next  = k_col;
    case (req_cmd)
      CMD_SET_SIZE: begin
        if (req_rin > MAX_N || req_cin > MAX_N) begin
          exec_status = ST_INDEX;
        end else begin
          rc_next = CW'(req_rin);
          cc_next = CW'(req_cin);
        end
      end
      CMD_WRITE, CMD_READ: begin
        if (NW'(req_row) >= rc_n || NW'(req_col) >= cc_n) exec_status = ST_INDEX;
      end
      CMD_STAGE: begin
        if (NW'(req_slot) >= MAX_N) exec_status = ST_INDEX;
      end
      CMD_INS_ROW: begin
        if (rc_n >= MAX_N) begin
          exec_status = ST_FULL;
        end else if (req_pos > rc_n) begin
          exec_status = ST_POS;
        end else begin
          rc_next = rc + CW'(1);
          if (req_pos < rc_n) begin
            exec_shift = 1'b1;
            k_next     = KW'(rc_n - NW'(1));
            k_end_next = KW'(req_pos);
            k_up_next  = 1'b0;
            k_col_next = 1'b0;
          end
        end
      end
      CMD_REM_ROW: begin
        if (req_pos >= rc_n) begin
          exec_status = ST_POS;
        end else begin
          rc_next = rc - CW'(1);
          if ((req_pos + NW'(1)) < rc_n) begin
            exec_shift = 1'b1;
            k_next     = KW'(req_pos);
            k_end_next = KW'(rc_n - NW'(2));
            k_up_next  = 1'b1;
            k_col_next = 1'b0;
          end
        end
      end
      CMD_INS_COL: begin
        if (cc_n >= MAX_N) begin
          exec_status = ST_FULL;
        end else if (req_pos > cc_n) begin
          exec_status = ST_POS;
        end else begin
          cc_next = cc + CW'(1);
          if (req_pos < cc_n) begin
            exec_shift = 1'b1;
            k_next     = KW'(cc_n - NW'(1));
            k_end_next = KW'(req_pos);
            k_up_next  = 1'b0;
            k_col_next = 1'b1;
          end
        end
      end
      CMD_REM_COL: begin
        if (req_pos >= cc_n) begin
          exec_status = ST_POS;
        end else begin
          cc_next = cc - CW'(1);
          if ((req_pos + NW'(1)) < cc_n) begin
            exec_shift = 1'b1;
            k_next     = KW'(req_pos);
            k_end_next = KW'(cc_n - NW'(2));
            k_up_next  = 1'b1;
            k_col_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = exec_shift ? S_SHIFT : S_DONE;
      S_SHIFT: if (k == k_end) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // cell control
  always_comb begin
    ctrl.op    = OP_NOP;
    ctrl.row_k = req_row;
    ctrl.col_k = req_col;
    ctrl.rc    = rc_n;
    ctrl.cc    = cc_n;
    ctrl.wdata = req_value;
    case (state)
      S_EXEC: begin
        if (exec_status == ST_OK) begin
          case (req_cmd)
            CMD_WRITE: ctrl.op = OP_WRITE;
            CMD_INS_ROW: begin
              ctrl.op    = OP_ROW_LOAD;
              ctrl.row_k = KW'(rc_n);
            end
            CMD_INS_COL: begin
              ctrl.op    = OP_COL_LOAD;
              ctrl.col_k = KW'(cc_n);
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        ctrl.op    = k_col ? OP_COL_SWAP : OP_ROW_SWAP;
        ctrl.row_k = k;
        ctrl.col_k = k;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rc     <= '0;
      cc     <= '0;
      staged <= '0;
      k      <= '0;
      k_end  <= '0;
      k_up   <= 1'b0;
      k_col  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        rc    <= rc_next;
        cc    <= cc_next;
        k     <= k_next;
        k_end <= k_end_next;
        k_up  <= k_up_next;
        k_col <= k_col_next;
        if (req_cmd == CMD_STAGE && exec_status == ST_OK) begin
          staged[req_slot[IW-1:0]] <= req_value;
        end
      end else if (state == S_SHIFT) begin
        k <= k_up ? k + KW'(1) : k - KW'(1);
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_cmd   <= cmd_t'(cmd);
      req_row   <= KW'(row_index);
      req_col   <= KW'(col_index);
      req_slot  <= KW'(slot);
      req_pos   <= NW'(position);
      req_rin   <= NW'(rows_in);
      req_cin   <= NW'(cols_in);
      req_value <= value;
    end
    if (state == S_EXEC) begin
      res_status <= exec_status;
      res_data   <= (req_cmd == CMD_READ && exec_status == ST_OK) ? rd_sel : '0;
    end
  end

  assign busy     = state != S_IDLE;
  assign done     = state == S_DONE;
  assign status   = res_status;
  assign data     = res_data;
  assign rows_now = 4'(rc);
  assign cols_now = 4'(cc);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done)) else $error("result too early");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    (rc_n <= MAX_N) && (cc_n <= MAX_N)) else $error("count above limit");

  a_swap_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (NW'(k) < (k_col ? cc_n : rc_n)))
    else $error("swap outside matrix");

endmodule

// File: tb/matrix_row_column_insert_remove_checker.sv
// ----------------------------------------------------------------------------
// matrix_row_column_insert_remove_checker
// Watches the request and result channels of the matrix insert/remove engine.
// Keeps its own copy of the matrix, the staged vector and the counts, works
// out the reply to every accepted request and compares each done strobe
// with the oldest reply still owed, field by field.
// ----------------------------------------------------------------------------
module matrix_row_column_insert_remove_checker
  import mrci_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         cmd,
  input  logic [2:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic [3:0]         position,
  input  logic [3:0]         rows_in,
  input  logic [3:0]         cols_in,
  input  logic [2:0]         slot,
  input  logic signed [31:0] value,
  input  logic               done,
  input  logic [1:0]         status,
  input  logic signed [31:0] data,
  input  logic [3:0]         rows_now,
  input  logic [3:0]         cols_now,
  output int                 mismatch_count,
  output int                 replies_owed
);

  typedef struct {
    status_t            st;
    logic signed [31:0] word;
    logic [3:0]         rows;
    logic [3:0]         cols;
  } reply_t;

  logic signed [31:0] grid [MAX_DIM][MAX_DIM];
  logic signed [31:0] staged [MAX_DIM];
  int                 row_cnt;
  int                 col_cnt;
  reply_t             owed_replies [$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic apply_request(input cmd_t op, input int ri, input int ci, input int pos,
                               input int rin, input int cin, input int sl,
                               input logic signed [31:0] val, output reply_t rep);
    int r;
    int c;
    logic signed [31:0] keep;
    rep.st   = ST_OK;
    rep.word = '0;
    case (op)
      CMD_SET_SIZE: begin
        if (rin > MAX_DIM || cin > MAX_DIM) rep.st = ST_INDEX;
        else begin
          row_cnt = rin;
          col_cnt = cin;
        end
      end
      CMD_WRITE: begin
        if (ri >= row_cnt || ci >= col_cnt) rep.st = ST_INDEX;
        else grid[ri][ci] = val;
      end
      CMD_STAGE: begin
        if (sl >= MAX_DIM) rep.st = ST_INDEX;
        else staged[sl] = val;
      end
      CMD_INS_ROW: begin
        if (row_cnt >= MAX_DIM) rep.st = ST_FULL;
        else if (pos > row_cnt) rep.st = ST_POS;
        else begin
          for (r = row_cnt; r > pos; r--)
            for (c = 0; c < col_cnt; c++) grid[r][c] = grid[r-1][c];
          for (c = 0; c < col_cnt; c++) grid[pos][c] = staged[c];
          row_cnt++;
        end
      end
      CMD_REM_ROW: begin
        if (pos >= row_cnt) rep.st = ST_POS;
        else begin
          // removed row rotates to the last used place
          for (c = 0; c < col_cnt; c++) begin
            keep = grid[pos][c];
            for (r = pos; r + 1 < row_cnt; r++) grid[r][c] = grid[r+1][c];
            grid[row_cnt-1][c] = keep;
          end
          row_cnt--;
        end
      end
      CMD_INS_COL: begin
        if (col_cnt >= MAX_DIM) rep.st = ST_FULL;
        else if (pos > col_cnt) rep.st = ST_POS;
        else begin
          for (r = 0; r < row_cnt; r++) begin
            for (c = col_cnt; c > pos; c--) grid[r][c] = grid[r][c-1];
            grid[r][pos] = staged[r];
          end
          col_cnt++;
        end
      end
      CMD_REM_COL: begin
        if (pos >= col_cnt) rep.st = ST_POS;
        else begin
          for (r = 0; r < row_cnt; r++) begin
            keep = grid[r][pos];
            for (c = pos; c + 1 < col_cnt; c++) grid[r][c] = grid[r][c+1];
            grid[r][col_cnt-1] = keep;
          end
          col_cnt--;
        end
      end
      default: begin
        if (ri >= row_cnt || ci >= col_cnt) rep.st = ST_INDEX;
        else rep.word = grid[ri][ci];
      end
    endcase
    rep.rows = row_cnt[3:0];
    rep.cols = col_cnt[3:0];
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t fresh;
    if (rst) begin
      for (int r = 0; r < MAX_DIM; r++) begin
        staged[r] = '0;
        for (int c = 0; c < MAX_DIM; c++) grid[r][c] = '0;
      end
      row_cnt = 0;
      col_cnt = 0;
      owed_replies.delete();
      mismatch_count = 0;
    end else begin
      if (done) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = owed_replies.pop_front();
          if (status !== want.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
          if (data !== want.word)
            report_mismatch($sformatf("data %0d, expected %0d", data, want.word));
          if (rows_now !== want.rows)
            report_mismatch($sformatf("rows_now %0d, expected %0d", rows_now, want.rows));
          if (cols_now !== want.cols)
            report_mismatch($sformatf("cols_now %0d, expected %0d", cols_now, want.cols));
        end
      end
      if (start && !busy) begin
        apply_request(cmd_t'(cmd), int'(row_index), int'(col_index), int'(position),
                      int'(rows_in), int'(cols_in), int'(slot), value, fresh);
        owed_replies.push_back(fresh);
      end
    end
    replies_owed <= owed_replies.size();
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the matrix row/column insert/remove engine. A directed run
// covers the extremes of the fields, every command and the error cases, then
// random requests follow, mostly well-formed against the counts last seen,
// under three idling profiles. The checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb;
  import mrci_pkg::*;

  localparam int MAX_DIM     = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 184;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         cmd = '0;
  logic [2:0]         row_index = '0;
  logic [2:0]         col_index = '0;
  logic [3:0]         position = '0;
  logic [3:0]         rows_in = '0;
  logic [3:0]         cols_in = '0;
  logic [2:0]         slot = '0;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [3:0]         rows_now;
  logic [3:0]         cols_now;

  int mismatches;
  int replies_owed;
  int idle_pct = 0;
  int rows_seen = 0;
  int cols_seen = 0;

  matrix_row_column_insert_remove_top #(.MAX_DIM(MAX_DIM)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .row_index(row_index), .col_index(col_index), .position(position),
    .rows_in(rows_in), .cols_in(cols_in), .slot(slot), .value(value),
    .done(done), .status(status), .data(data), .rows_now(rows_now),
    .cols_now(cols_now)
  );

  matrix_row_column_insert_remove_checker #(.MAX_DIM(MAX_DIM)) matrix_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .row_index(row_index), .col_index(col_index), .position(position),
    .rows_in(rows_in), .cols_in(cols_in), .slot(slot), .value(value),
    .done(done), .status(status), .data(data), .rows_now(rows_now),
    .cols_now(cols_now), .mismatch_count(mismatches), .replies_owed(replies_owed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (done) begin
      rows_seen <= int'(rows_now);
      cols_seen <= int'(cols_now);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_request(input cmd_t op, input logic [2:0] ri, input logic [2:0] ci,
                              input logic [3:0] pos, input logic [3:0] rin,
                              input logic [3:0] cin, input logic [2:0] sl,
                              input logic signed [31:0] val);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start     <= 1'b1;
    cmd       <= op;
    row_index <= ri;
    col_index <= ci;
    position  <= pos;
    rows_in   <= rin;
    cols_in   <= cin;
    slot      <= sl;
    value     <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_request(input bit noise);
    int w;
    cmd_t op;
    logic [2:0] ri;
    logic [2:0] ci;
    logic [3:0] pos;
    logic [3:0] rin;
    logic [3:0] cin;
    logic signed [31:0] val;
    case ($urandom_range(9))
      0: val = 32'sh80000000;
      1: val = 32'sh7fffffff;
      2: val = -1;
      3: val = 0;
      default: val = $urandom;
    endcase
    if (noise) begin
      send_request(cmd_t'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                   4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)),
                   3'($urandom_range(7)), val);
    end else begin
      w = $urandom_range(99);
      if (w < 5) op = CMD_SET_SIZE;
      else if (w < 24) op = CMD_WRITE;
      else if (w < 40) op = CMD_STAGE;
      else if (w < 52) op = CMD_INS_ROW;
      else if (w < 64) op = CMD_REM_ROW;
      else if (w < 76) op = CMD_INS_COL;
      else if (w < 88) op = CMD_REM_COL;
      else op = CMD_READ;
      ri  = (rows_seen > 0) ? 3'($urandom_range(rows_seen - 1)) : 3'd0;
      ci  = (cols_seen > 0) ? 3'($urandom_range(cols_seen - 1)) : 3'd0;
      rin = 4'($urandom_range(MAX_DIM));
      cin = 4'($urandom_range(MAX_DIM));
      case (op)
        CMD_INS_ROW: pos = 4'($urandom_range(rows_seen));
        CMD_REM_ROW: pos = (rows_seen > 0) ? 4'($urandom_range(rows_seen - 1)) : 4'd0;
        CMD_INS_COL: pos = 4'($urandom_range(cols_seen));
        CMD_REM_COL: pos = (cols_seen > 0) ? 4'($urandom_range(cols_seen - 1)) : 4'd0;
        default: pos = 4'($urandom_range(15));
      endcase
      send_request(op, ri, ci, pos, rin, cin, 3'($urandom_range(7)), val);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 27;

    // empty matrix, oversized counts, then a small matrix
    send_request(CMD_READ,     0, 0, 0,  0,  0, 0, 0);
    send_request(CMD_SET_SIZE, 0, 0, 0, 15,  2, 0, 0);
    send_request(CMD_SET_SIZE, 0, 0, 0,  2,  9, 0, 0);
    send_request(CMD_SET_SIZE, 0, 0, 0,  2,  3, 0, 0);
    send_request(CMD_WRITE,    0, 0, 0,  0,  0, 0, 32'sh80000000);
    send_request(CMD_WRITE,    1, 2, 0,  0,  0, 0, 32'sh7fffffff);
    send_request(CMD_WRITE,    2, 0, 0,  0,  0, 0, 5);
    send_request(CMD_STAGE,    0, 0, 0,  0,  0, 0, -1);
    send_request(CMD_STAGE,    0, 0, 0,  0,  0, 2, 32'sh80000000);
    send_request(CMD_STAGE,    0, 0, 0,  0,  0, 7, 32'sh7fffffff);
    // row insert past the end, in the middle, appended; row removal; then column ops
    send_request(CMD_INS_ROW,  0, 0, 3,  0,  0, 0, 0);
    send_request(CMD_INS_ROW,  0, 0, 1,  0,  0, 0, 0);
    send_request(CMD_INS_ROW,  0, 0, 3,  0,  0, 0, 0);
    send_request(CMD_REM_ROW,  0, 0, 4,  0,  0, 0, 0);
    send_request(CMD_REM_ROW,  0, 0, 0,  0,  0, 0, 0);
    send_request(CMD_INS_COL,  0, 0, 0,  0,  0, 0, 0);
    send_request(CMD_INS_COL,  0, 0, 15, 0,  0, 0, 0);
    send_request(CMD_REM_COL,  0, 0, 2,  0,  0, 0, 0);
    send_request(CMD_READ,     2, 7, 0,  0,  0, 0, 0);
    // full matrix: full check comes before the position check
    send_request(CMD_SET_SIZE, 0, 0, 0,  8,  8, 0, 0);
    send_request(CMD_INS_ROW,  0, 0, 15, 0,  0, 0, 0);
    send_request(CMD_INS_COL,  0, 0, 15, 0,  0, 0, 0);
    send_request(CMD_WRITE,    7, 7, 0,  0,  0, 0, -1);
    send_request(CMD_READ,     7, 7, 0,  0,  0, 0, 0);
    send_request(CMD_SET_SIZE, 0, 0, 0,  0,  0, 0, 0);
    send_request(CMD_REM_ROW,  0, 0, 0,  0,  0, 0, 0);
    send_request(CMD_REM_COL,  0, 0, 0,  0,  0, 0, 0);

    repeat (RAND_ITEMS) random_request($urandom_range(9) == 0);
    idle_pct = 58;
    repeat (RAND_ITEMS) random_request($urandom_range(9) == 0);
    idle_pct = 0;
    repeat (RAND_ITEMS) random_request($urandom_range(9) == 0);
    start <= 1'b0;

    do @(posedge clk); while (replies_owed != 0);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && replies_owed == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/mrci_pkg.sv
hdl/mrci_row.sv
hdl/matrix_row_column_insert_remove_top.sv
tb/matrix_row_column_insert_remove_checker.sv
tb/tb.sv
